### hw/rtl/dense_rank_tracker_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dense rank tracker
// Shared property forms, clocked on aclk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DENSE_RANK_TRACKER_TOP_MACROS_SVH
`define DENSE_RANK_TRACKER_TOP_MACROS_SVH

// Condition must hold at every clock edge outside reset
`define DRT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define DRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define DRT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

### hw/rtl/drt_pkg.sv
// ----------------------------------------------------------------------------
// drt_pkg
// Shared widths, item codes and controller states of the dense rank tracker.
// ----------------------------------------------------------------------------
package drt_pkg;

    // Default table size
    localparam int TABLE_DEPTH_DEF = 1024;

    // Field widths
    localparam int MODE_W  = 2;
    localparam int SCORE_W = 31;
    localparam int RANK_W  = 11;

    // Padded bus widths
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 16;

    // Item kinds carried in tuser
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_EMIT
    } drt_state_t;

endpackage

### hw/rtl/dense_rank_tracker_top.sv
// ----------------------------------------------------------------------------
// dense_rank_tracker_top
// Dense ranking of sorted queries against a table of distinct scores.
// ----------------------------------------------------------------------------
// Input channel s_: s_tuser selects the item kind (clear, load, query),
// s_tdata carries the 31-bit score. Result channel m_: one item per query,
// m_tdata carries the 11-bit dense rank (1 is best).
// Clear and load items are taken in the idle state; a load writes the score table
// directly unless it repeats the last stored score or the table is full.
// A query walks the pointer down in the compare step, passing each entry that
// does not beat the query, until an entry beats it or every entry is passed;
// a start at pointer zero (empty table) skips the walk. The pointer only moves
// down, so over a sorted query run each entry is passed at most once through
// the table's single read port. m_tvalid comes from the register the emit step loads.
// Only one item is in work at a time: s_tready is high while the controller
// is idle. A finished rank sits in the output register; a stalled receiver
// holds a later query in the emit step, and loads or clears that come before
// that query are still taken while the register is full.
// Reset (aresetn low, synchronous) empties the table and drops any pending
// result; table contents need no clearing pass, as only entries below the
// count are ever compared.
// ----------------------------------------------------------------------------
module dense_rank_tracker_top #(
    parameter int TABLE_DEPTH = drt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [drt_pkg::S_DATA_W-1:0]  s_tdata,  // [30:0] score_value
    input  logic [drt_pkg::MODE_W-1:0]    s_tuser,  // [1:0] mode
    // Result items
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [drt_pkg::M_DATA_W-1:0]  m_tdata   // [10:0] rank
);
    import drt_pkg::*;

    `include "dense_rank_tracker_top_macros.svh"

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    drt_state_t state_reg, state_next;

    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]      ptr_reg, ptr_next;
    logic               started_reg, started_next;
    logic [SCORE_W-1:0] last_reg, last_next;
    logic [SCORE_W-1:0] query_reg, query_next;
    logic               m_valid_reg, m_valid_next;
    logic [RANK_W-1:0]  m_rank_reg, m_rank_next;

    logic               in_fire;
    logic [MODE_W-1:0]  in_mode;
    logic [SCORE_W-1:0] in_score;
    logic [CW-1:0]      start_ptr;
    logic               out_free;
    logic               load_ok;
    logic               step_hit;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [AW-1:0]      mem_raddr;
    logic [SCORE_W-1:0] mem_rdata;

    assign in_mode   = s_tuser;
    assign in_score  = s_tdata[SCORE_W-1:0];
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign start_ptr = started_reg ? ptr_reg : cnt_reg;
    assign load_ok   = !(cnt_reg != '0 && last_reg == in_score)
                       && (cnt_reg < CW'(TABLE_DEPTH));
    assign step_hit  = (mem_rdata <= query_reg);

    // Score table
    drt_score_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (in_score),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire && in_mode == MODE_QUERY) begin
                    state_next = (start_ptr == '0) ? ST_EMIT : ST_CMP;
                end
            end
            ST_CMP: begin
                if (!step_hit || ptr_reg == CW'(1)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Controller outputs: handshake, table ports
    always_comb begin
        s_tready  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = cnt_reg[AW-1:0];
        mem_raddr = AW'(start_ptr - CW'(1));
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                mem_we   = s_tvalid && in_mode == MODE_LOAD && load_ok;
            end
            ST_CMP: begin
                // speculative read of the next entry down
                mem_raddr = AW'(ptr_reg - CW'(2));
            end
            ST_EMIT: begin
                mem_raddr = AW'(ptr_reg - CW'(1));
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Datapath registers
    always_comb begin
        cnt_next     = cnt_reg;
        ptr_next     = ptr_reg;
        started_next = started_reg;
        last_next    = last_reg;
        query_next   = query_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_rank_next  = m_rank_reg;

        if (state_reg == ST_IDLE && in_fire) begin
            case (in_mode)
                MODE_CLEAR: begin
                    cnt_next     = '0;
                    ptr_next     = '0;
                    started_next = 1'b0;
                end
                MODE_LOAD: begin
                    if (load_ok) begin
                        cnt_next     = cnt_reg + CW'(1);
                        last_next    = in_score;
                        started_next = 1'b0;
                    end
                end
                MODE_QUERY: begin
                    ptr_next     = start_ptr;
                    started_next = 1'b1;
                    query_next   = in_score;
                end
                default: begin
                    cnt_next = cnt_reg;
                end
            endcase
        end

        // Walk step: pass an entry that does not beat the query
        if (state_reg == ST_CMP && step_hit) begin
            ptr_next = ptr_reg - CW'(1);
        end

        // Hand the rank to the output register
        if (state_reg == ST_EMIT && out_free) begin
            m_valid_next = 1'b1;
            m_rank_next  = RANK_W'(ptr_reg) + RANK_W'(1);
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            ptr_reg     <= '0;
            started_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            ptr_reg     <= ptr_next;
            started_reg <= started_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        last_reg   <= last_next;
        query_reg  <= query_next;
        m_rank_reg <= m_rank_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'(m_rank_reg);

    // Checks
    `DRT_ASSERT_ALWAYS(a_ptr_in_table, !started_reg || ptr_reg <= cnt_reg, "pointer above count")
    `DRT_ASSERT_IMPL(a_cmp_ptr_nonzero, state_reg == ST_CMP, ptr_reg != '0, "compare at zero")
    `DRT_ASSERT_NEXT(a_load_grows, mem_we, cnt_reg == $past(cnt_reg) + CW'(1), "count not grown")

endmodule

### hw/rtl/drt_score_mem.sv
// ----------------------------------------------------------------------------
// drt_score_mem
// Score table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module drt_score_mem #(
    parameter int DEPTH = drt_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [drt_pkg::SCORE_W-1:0] wr_data,
    input  logic [AW-1:0]              rd_addr,
    output logic [drt_pkg::SCORE_W-1:0] rd_data
);
    import drt_pkg::*;

    logic [SCORE_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule
